FILE: hw/rtl/mrwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrwr_pkg
// Types, constants and the CRC-16 byte update for the Modbus RTU
// speed-write master.
// ----------------------------------------------------------------------------
package mrwr_pkg;

    localparam int FRAME_BODY_BYTES = 6;
    localparam int FRAME_BYTES      = FRAME_BODY_BYTES + 2;
    localparam int IDX_W            = $clog2(FRAME_BYTES);
    localparam int CNT_W            = 4;

    localparam logic [CNT_W-1:0] BODY_CNT  = CNT_W'(FRAME_BODY_BYTES);
    localparam logic [CNT_W-1:0] FINAL_CNT = CNT_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] REG_SPEED         = 16'h000B;

    localparam logic [7:0] STATION_RESET = 8'd1;
    localparam logic [3:0] LIMIT_RESET   = 4'd5;

    // register indexes on the configuration port
    localparam logic REG_STATION_ID    = 1'b0;
    localparam logic REG_ATTEMPT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_SPEED   = 2'd0,
        OP_RX      = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_FAIL = 2'd2,
        KIND_BUSY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_ATTEMPT,
        ST_SEND,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic  latch_item;
        logic  start_req;
        logic  start_retry;
        logic  rx_check;
        logic  finish;
        logic  send_byte;
        logic  load_single;
        kind_t single_kind;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic awaiting;
        logic speed_match;
        logic reply_final;
        logic reply_bad;
        logic retry_ok;
        logic out_free;
        logic send_last;
    } dp_sts_t;

    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mrwr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrwr_if
// Request and response channels of the speed-write master.
// ----------------------------------------------------------------------------
interface mrwr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] speed;
    logic [7:0]  rx_byte;

    modport source (output valid, op, speed, rx_byte, input ready);
    modport sink   (input valid, op, speed, rx_byte, output ready);
endinterface

interface mrwr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, kind, tx_byte, last, input ready);
    modport sink   (input valid, kind, tx_byte, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mrwr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrwr_datapath
// Transaction state, frame byte generation with running CRC, reply checker
// and the output register.
// ----------------------------------------------------------------------------
module mrwr_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mrwr_pkg::dp_cmd_t   cmd,
    output mrwr_pkg::dp_sts_t   sts,
    input  wire  [1:0]          in_op,
    input  wire  [15:0]         in_speed,
    input  wire  [7:0]          in_rx_byte,
    input  wire  [7:0]          station_id,
    input  wire  [3:0]          attempt_limit,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import mrwr_pkg::*;

    logic [1:0]       op_reg;
    logic [15:0]      speed_reg;
    logic [7:0]       rx_reg;

    logic [15:0]      last_speed_reg, last_speed_next;
    logic             last_valid_reg, last_valid_next;
    logic [15:0]      frame_speed_reg, frame_speed_next;
    logic             awaiting_reg, awaiting_next;
    logic [CNT_W-1:0] reply_count_reg, reply_count_next;
    logic [15:0]      reply_crc_reg, reply_crc_next;
    logic             reply_bad_reg, reply_bad_next;
    logic [3:0]       attempts_reg, attempts_next;
    logic [15:0]      send_crc_reg, send_crc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       frame_byte;
    logic             start_frame;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg    <= in_op;
            speed_reg <= in_speed;
            rx_reg    <= in_rx_byte;
        end
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_speed_reg  <= '0;
            last_valid_reg  <= 1'b0;
            frame_speed_reg <= '0;
            awaiting_reg    <= 1'b0;
            reply_count_reg <= '0;
            reply_crc_reg   <= CRC_INIT;
            reply_bad_reg   <= 1'b0;
            attempts_reg    <= '0;
            send_crc_reg    <= CRC_INIT;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_speed_reg  <= last_speed_next;
            last_valid_reg  <= last_valid_next;
            frame_speed_reg <= frame_speed_next;
            awaiting_reg    <= awaiting_next;
            reply_count_reg <= reply_count_next;
            reply_crc_reg   <= reply_crc_next;
            reply_bad_reg   <= reply_bad_next;
            attempts_reg    <= attempts_next;
            send_crc_reg    <= send_crc_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    frame_byte = station_id;
            3'd1:    frame_byte = FUNC_WRITE_SINGLE;
            3'd2:    frame_byte = REG_SPEED[15:8];
            3'd3:    frame_byte = REG_SPEED[7:0];
            3'd4:    frame_byte = frame_speed_reg[15:8];
            3'd5:    frame_byte = frame_speed_reg[7:0];
            3'd6:    frame_byte = send_crc_reg[7:0];
            default: frame_byte = send_crc_reg[15:8];
        endcase
    end

    assign start_frame = cmd.start_req || cmd.start_retry;

    always_comb
    begin
        last_speed_next  = last_speed_reg;
        last_valid_next  = last_valid_reg;
        frame_speed_next = frame_speed_reg;
        awaiting_next    = awaiting_reg;
        reply_count_next = reply_count_reg;
        reply_crc_next   = reply_crc_reg;
        reply_bad_next   = reply_bad_reg;
        attempts_next    = attempts_reg;
        send_crc_next    = send_crc_reg;
        idx_next         = idx_reg;
        out_kind_next    = out_kind_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.start_req)
        begin
            last_speed_next  = speed_reg;
            last_valid_next  = 1'b1;
            frame_speed_next = speed_reg;
            awaiting_next    = 1'b1;
            attempts_next    = 4'd1;
        end
        if (cmd.start_retry)
        begin
            attempts_next = attempts_reg + 4'd1;
        end
        if (start_frame)
        begin
            idx_next         = '0;
            send_crc_next    = CRC_INIT;
            reply_count_next = '0;
            reply_crc_next   = CRC_INIT;
            reply_bad_next   = 1'b0;
        end

        if (cmd.rx_check)
        begin
            if (reply_count_reg == '0 && rx_reg != station_id)
            begin
                reply_bad_next = 1'b1;
            end
            if (reply_count_reg < BODY_CNT)
            begin
                reply_crc_next = crc_feed(reply_crc_reg, rx_reg);
            end
            else if (reply_count_reg == BODY_CNT)
            begin
                if (rx_reg != reply_crc_reg[7:0])
                begin
                    reply_bad_next = 1'b1;
                end
            end
            else if (rx_reg != reply_crc_reg[15:8])
            begin
                reply_bad_next = 1'b1;
            end
            reply_count_next = reply_count_reg + CNT_W'(1);
        end

        if (cmd.finish)
        begin
            awaiting_next    = 1'b0;
            reply_count_next = '0;
            reply_crc_next   = CRC_INIT;
            reply_bad_next   = 1'b0;
        end

        if (cmd.send_byte)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_TX;
            out_byte_next  = frame_byte;
            out_last_next  = (idx_reg == LAST_IDX);
            if (idx_reg < IDX_W'(FRAME_BODY_BYTES))
            begin
                send_crc_next = crc_feed(send_crc_reg, frame_byte);
            end
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.load_single)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.single_kind;
            out_byte_next  = 8'h00;
            out_last_next  = 1'b1;
        end
    end

    always_comb
    begin
        sts.op          = op_t'(op_reg);
        sts.awaiting    = awaiting_reg;
        sts.speed_match = last_valid_reg && (speed_reg == last_speed_reg);
        sts.reply_final = (reply_count_reg == FINAL_CNT);
        sts.reply_bad   = reply_bad_reg;
        sts.retry_ok    = (attempts_reg < attempt_limit);
        sts.out_free    = !out_valid_reg || out_ready;
        sts.send_last   = (idx_reg == LAST_IDX);
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/mrwr_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrwr_controller
// Sequencer for request decode, reply evaluation, retries and frame output.
// ----------------------------------------------------------------------------
module mrwr_controller (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  mrwr_pkg::dp_sts_t   sts,
    output mrwr_pkg::dp_cmd_t   cmd
);
    import mrwr_pkg::*;

    state_t state_reg, state_next;
    kind_t  single_reg, single_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            single_reg <= KIND_ACK;
        end
        else
        begin
            state_reg  <= state_next;
            single_reg <= single_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        single_next     = single_reg;
        cmd             = '0;
        cmd.single_kind = single_reg;
        in_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (sts.op)
                    OP_SPEED:
                    begin
                        if (sts.awaiting)
                        begin
                            single_next = KIND_BUSY;
                            state_next  = ST_SINGLE;
                        end
                        else if (!sts.speed_match)
                        begin
                            cmd.start_req = 1'b1;
                            state_next    = ST_SEND;
                        end
                    end
                    OP_RX:
                    begin
                        if (sts.awaiting)
                        begin
                            cmd.rx_check = 1'b1;
                            if (sts.reply_final)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                    end
                    OP_TIMEOUT:
                    begin
                        if (sts.awaiting)
                        begin
                            state_next = ST_ATTEMPT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_CHECK:
            begin
                if (sts.reply_bad)
                begin
                    state_next = ST_ATTEMPT;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    single_next = KIND_ACK;
                    state_next  = ST_SINGLE;
                end
            end

            ST_ATTEMPT:
            begin
                if (sts.retry_ok)
                begin
                    cmd.start_retry = 1'b1;
                    state_next      = ST_SEND;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    single_next = KIND_FAIL;
                    state_next  = ST_SINGLE;
                end
            end

            ST_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.send_byte = 1'b1;
                    if (sts.send_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/modbus_rtu_write_register_master_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_write_register_master_unit
// Modbus RTU master that writes the speed register (function 0x06, reg 0x000B).
//
// req carries one event per request: op 0 is a speed request, op 1 a received
// reply byte, op 2 a reply timeout. rsp returns transmit bytes (kind 0, last
// set on the eighth frame byte) or a single status item: acknowledged, failed
// after the attempt limit, or request dropped while busy.
// A request that sends a frame passes from decode to the frame sequencer, which
// emits one byte a cycle while the output is free, and the block is ready
// again once the last frame byte is loaded. A reply byte updates the reply
// check; the final reply byte gives an ack, or a retry frame or a fail once
// the attempt limit is reached. A timeout gives a retry frame or a fail.
// The transmit CRC is updated one byte per cycle in the datapath while the output is free.
// If the receiver stalls, the output register holds its item and the
// sequencer waits; no item is lost or repeated.
// Reset clears all transaction state, station_id to 1 and attempt_limit to 5.
// station_id sits at address 0x0, attempt_limit at 0x4.
// ----------------------------------------------------------------------------
module modbus_rtu_write_register_master_unit (
    input  wire        clk,
    input  wire        rst_n,
    mrwr_req_if.sink   req,
    mrwr_rsp_if.source rsp,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire  [2:0] paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrwr_pkg::*;

    logic [7:0] station_id_reg;
    logic [3:0] attempt_limit_reg;
    logic       cfg_write;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg    <= STATION_RESET;
            attempt_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_STATION_ID)
            begin
                station_id_reg <= pwdata[7:0];
            end
            else
            begin
                attempt_limit_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ATTEMPT_LIMIT)
        begin
            prdata = {28'h0, attempt_limit_reg};
        end
        else
        begin
            prdata = {24'h0, station_id_reg};
        end
    end

    mrwr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrwr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (req.op),
        .in_speed      (req.speed),
        .in_rx_byte    (req.rx_byte),
        .station_id    (station_id_reg),
        .attempt_limit (attempt_limit_reg),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_kind      (rsp.kind),
        .out_byte      (rsp.tx_byte),
        .out_last      (rsp.last)
    );

endmodule
`default_nettype wire
